FILE: sv/scc_pkg.sv
`timescale 1ns / 1ps
// scc_pkg: shared types, codes and keyword ROM for the C source character classifier.
// No dependencies.
package scc_pkg;

    localparam int MAX_KEYWORD_LEN = 8;
    localparam int NUM_KEYWORDS    = 22;
    localparam int QUEUE_DEPTH     = 2;

    localparam int WLEN_W  = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int CNT_W   = $clog2(2 * MAX_KEYWORD_LEN + 3);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int KW_BITS = 8 * MAX_KEYWORD_LEN;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_BLOCK   = 3'd1;
    localparam logic [2:0] MODE_LINE    = 3'd2;
    localparam logic [2:0] MODE_DQUOTE  = 3'd3;
    localparam logic [2:0] MODE_SQUOTE  = 3'd4;
    localparam logic [2:0] MODE_PREPROC = 3'd5;

    localparam logic [2:0] ST_PLAIN   = 3'd0;
    localparam logic [2:0] ST_COMMENT = 3'd1;
    localparam logic [2:0] ST_STRING  = 3'd2;
    localparam logic [2:0] ST_KEYWORD = 3'd3;
    localparam logic [2:0] ST_PREPROC = 3'd4;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;

    // Text is right-aligned: the last character sits in the low byte.
    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        KW_BITS'("asm"), KW_BITS'("break"), KW_BITS'("case"), KW_BITS'("const"),
        KW_BITS'("continue"), KW_BITS'("default"), KW_BITS'("do"), KW_BITS'("else"),
        KW_BITS'("extern"), KW_BITS'("false"), KW_BITS'("for"), KW_BITS'("goto"),
        KW_BITS'("if"), KW_BITS'("return"), KW_BITS'("static"), KW_BITS'("struct"),
        KW_BITS'("switch"), KW_BITS'("true"), KW_BITS'("typedef"), KW_BITS'("union"),
        KW_BITS'("volatile"), KW_BITS'("while")
    };

    localparam int KW_LEN [NUM_KEYWORDS] = '{
        3, 5, 4, 5, 8, 7, 2, 4, 6, 5, 3, 4, 2, 6, 6, 6, 6, 4, 7, 5, 8, 5
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [2:0] style_code;
        logic       last_of_run;
    } out_item_t;

    // Result list of one byte: held style, word run, flushed held style, flushed word run.
    typedef struct packed {
        logic              h1_valid;
        logic [2:0]        h1_style;
        logic [WLEN_W-1:0] w1_count;
        logic [2:0]        w1_style;
        logic              h2_valid;
        logic [2:0]        h2_style;
        logic [WLEN_W-1:0] w2_count;
        logic [CNT_W-1:0]  total;
    } cmd_t;

    function automatic logic [7:0] kw_byte(input int k, input int j);
        logic [KW_BITS-1:0] t;
        int sh;
        t = KW_TEXT[k];
        if (j >= KW_LEN[k] || j < 0) begin
            return 8'd0;
        end
        sh = (KW_LEN[k] - 1 - j) * 8;
        return t[sh +: 8];
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDERLINE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: sv/c_source_char_classifier.sv
`timescale 1ns / 1ps
// c_source_char_classifier: top level; front lexer, command queue, result sequencer.
// A byte's command is written into the queue; the sequencer then registers its first result
// into the output stage once nothing is queued ahead of it.
// Throughput: one byte per cycle in while byte_stall is low, one result per cycle out
// while style_stall is low; a byte's k results (k up to 9) hold the sequencer until all are out.
// Reset: asynchronous, clears lexer state, queue and output stage; no clearing pass.
// Depends on scc_pkg, scc_front, scc_queue, scc_back.
module c_source_char_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  scc_pkg::in_item_t  byte_data,
    output logic               style_valid,
    input  logic               style_stall,
    output scc_pkg::out_item_t style_data
);

    logic          take;
    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    scc_pkg::cmd_t cmd;
    scc_pkg::cmd_t head_cmd;

    assign byte_stall = full;
    assign take       = byte_valid && !full;

    scc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_data),
        .push  (push),
        .cmd   (cmd)
    );

    scc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    scc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (style_valid),
        .out_stall  (style_stall),
        .out_data   (style_data)
    );

endmodule

FILE: sv/scc_front.sv
`timescale 1ns / 1ps
// scc_front: lexer mode tracking and incremental keyword match, one byte per cycle while take is high.
// Pushes one result-list command per byte whose result list is not empty. Depends on scc_pkg.
module scc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  scc_pkg::in_item_t item,
    output logic             push,
    output scc_pkg::cmd_t    cmd
);

    localparam logic [scc_pkg::WLEN_W-1:0] WLEN_ONE = scc_pkg::WLEN_W'(1);
    localparam logic [scc_pkg::WLEN_W-1:0] WLEN_MAX =
        scc_pkg::WLEN_W'(scc_pkg::MAX_KEYWORD_LEN);

    logic [2:0]                           mode_reg, mode_next;
    logic [7:0]                           prev_reg, prev_next;
    logic                                 esc_reg, esc_next;
    logic                                 clean_reg, clean_next;
    logic [scc_pkg::WLEN_W-1:0]           wlen_reg, wlen_next;
    logic                                 long_reg, long_next;
    logic [2:0]                           hstyle_reg, hstyle_next;
    logic                                 hvalid_reg, hvalid_next;
    logic [scc_pkg::NUM_KEYWORDS-1:0]     mask_reg, mask_next;

    logic [scc_pkg::NUM_KEYWORDS-1:0]     byte_hit;
    logic [scc_pkg::NUM_KEYWORDS-1:0]     len_hit;
    logic                                 is_kw;
    logic [7:0]                           c;

    assign c = item.char_code;

    always_comb
    begin
        for (int k = 0; k < scc_pkg::NUM_KEYWORDS; k++)
        begin
            byte_hit[k] = scc_pkg::kw_byte(k, int'(wlen_reg)) == c;
            len_hit[k]  = scc_pkg::KW_LEN[k] == int'(wlen_reg);
        end
        is_kw = (wlen_reg != '0) && |(mask_reg & len_hit);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prev_next   = c;
        esc_next    = esc_reg ? 1'b0 : (prev_reg == scc_pkg::CH_BACKSLASH);
        clean_next  = clean_reg;
        wlen_next   = wlen_reg;
        long_next   = long_reg;
        hstyle_next = hstyle_reg;
        hvalid_next = hvalid_reg;
        mask_next   = mask_reg;
        cmd         = '0;

        unique case (mode_reg)
            scc_pkg::MODE_BLOCK:
            begin
                cmd.h1_valid = hvalid_reg;
                cmd.h1_style = hstyle_reg;
                hvalid_next  = 1'b1;
                hstyle_next  = scc_pkg::ST_COMMENT;
                if (prev_reg == scc_pkg::CH_STAR && c == scc_pkg::CH_SLASH)
                begin
                    mode_next = scc_pkg::MODE_NORMAL;
                end
            end
            scc_pkg::MODE_LINE, scc_pkg::MODE_PREPROC:
            begin
                cmd.h1_valid = hvalid_reg;
                cmd.h1_style = hstyle_reg;
                hvalid_next  = 1'b1;
                hstyle_next  = (mode_reg == scc_pkg::MODE_LINE) ?
                               scc_pkg::ST_COMMENT : scc_pkg::ST_PREPROC;
                if (c == scc_pkg::CH_NEWLINE)
                begin
                    mode_next  = scc_pkg::MODE_NORMAL;
                    clean_next = 1'b1;
                end
            end
            scc_pkg::MODE_DQUOTE, scc_pkg::MODE_SQUOTE:
            begin
                cmd.h1_valid = hvalid_reg;
                cmd.h1_style = hstyle_reg;
                hvalid_next  = 1'b1;
                hstyle_next  = scc_pkg::ST_STRING;
                if (!esc_next &&
                    c == ((mode_reg == scc_pkg::MODE_DQUOTE) ?
                          scc_pkg::CH_DQUOTE : scc_pkg::CH_SQUOTE))
                begin
                    mode_next = scc_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                mode_next = scc_pkg::MODE_NORMAL;
                priority if (prev_reg == scc_pkg::CH_SLASH &&
                             (c == scc_pkg::CH_STAR || c == scc_pkg::CH_SLASH))
                begin
                    cmd.h1_valid = hvalid_reg;
                    cmd.h1_style = scc_pkg::ST_COMMENT;
                    cmd.w1_count = wlen_reg;
                    cmd.w1_style = scc_pkg::ST_PLAIN;
                    wlen_next    = '0;
                    long_next    = 1'b0;
                    hvalid_next  = 1'b1;
                    hstyle_next  = scc_pkg::ST_COMMENT;
                    mode_next    = (c == scc_pkg::CH_STAR) ?
                                   scc_pkg::MODE_BLOCK : scc_pkg::MODE_LINE;
                end
                else if (c == scc_pkg::CH_DQUOTE || c == scc_pkg::CH_SQUOTE)
                begin
                    cmd.h1_valid = hvalid_reg;
                    cmd.h1_style = hstyle_reg;
                    cmd.w1_count = wlen_reg;
                    cmd.w1_style = scc_pkg::ST_PLAIN;
                    wlen_next    = '0;
                    long_next    = 1'b0;
                    hvalid_next  = 1'b1;
                    hstyle_next  = scc_pkg::ST_STRING;
                    mode_next    = (c == scc_pkg::CH_DQUOTE) ?
                                   scc_pkg::MODE_DQUOTE : scc_pkg::MODE_SQUOTE;
                end
                else if (c == scc_pkg::CH_HASH && clean_reg)
                begin
                    cmd.h1_valid = hvalid_reg;
                    cmd.h1_style = hstyle_reg;
                    cmd.w1_count = wlen_reg;
                    cmd.w1_style = scc_pkg::ST_PLAIN;
                    wlen_next    = '0;
                    long_next    = 1'b0;
                    hvalid_next  = 1'b1;
                    hstyle_next  = scc_pkg::ST_PREPROC;
                    mode_next    = scc_pkg::MODE_PREPROC;
                end
                else
                begin
                    if (scc_pkg::is_ident(c))
                    begin
                        priority if (long_reg)
                        begin
                            cmd.h1_valid = hvalid_reg;
                            cmd.h1_style = hstyle_reg;
                            hvalid_next  = 1'b1;
                            hstyle_next  = scc_pkg::ST_PLAIN;
                        end
                        else if (wlen_reg == '0)
                        begin
                            cmd.h1_valid = hvalid_reg;
                            cmd.h1_style = hstyle_reg;
                            hvalid_next  = 1'b0;
                            mask_next    = byte_hit;
                            wlen_next    = WLEN_ONE;
                        end
                        else if (wlen_reg < WLEN_MAX)
                        begin
                            mask_next = mask_reg & byte_hit;
                            wlen_next = wlen_reg + WLEN_ONE;
                        end
                        else
                        begin
                            cmd.h1_valid = hvalid_reg;
                            cmd.h1_style = hstyle_reg;
                            cmd.w1_count = wlen_reg;
                            cmd.w1_style = scc_pkg::ST_PLAIN;
                            wlen_next    = '0;
                            long_next    = 1'b1;
                            hvalid_next  = 1'b1;
                            hstyle_next  = scc_pkg::ST_PLAIN;
                        end
                    end
                    else
                    begin
                        cmd.h1_valid = hvalid_reg;
                        cmd.h1_style = hstyle_reg;
                        cmd.w1_count = wlen_reg;
                        cmd.w1_style = is_kw ? scc_pkg::ST_KEYWORD : scc_pkg::ST_PLAIN;
                        wlen_next    = '0;
                        long_next    = 1'b0;
                        hvalid_next  = 1'b1;
                        hstyle_next  = scc_pkg::ST_PLAIN;
                    end
                    if (!scc_pkg::is_blank(c))
                    begin
                        clean_next = 1'b0;
                    end
                    else if (c == scc_pkg::CH_NEWLINE)
                    begin
                        clean_next = 1'b1;
                    end
                end
            end
        endcase

        if (item.end_of_text)
        begin
            cmd.h2_valid = hvalid_next;
            cmd.h2_style = hstyle_next;
            cmd.w2_count = wlen_next;
            hvalid_next  = 1'b0;
            mode_next    = scc_pkg::MODE_NORMAL;
            prev_next    = 8'd0;
            esc_next     = 1'b0;
            clean_next   = 1'b1;
            wlen_next    = '0;
            long_next    = 1'b0;
        end

        cmd.total = scc_pkg::CNT_W'(cmd.h1_valid) + scc_pkg::CNT_W'(cmd.w1_count) +
                    scc_pkg::CNT_W'(cmd.h2_valid) + scc_pkg::CNT_W'(cmd.w2_count);
    end

    assign push = take && (cmd.total != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= scc_pkg::MODE_NORMAL;
            prev_reg   <= 8'd0;
            esc_reg    <= 1'b0;
            clean_reg  <= 1'b1;
            wlen_reg   <= '0;
            long_reg   <= 1'b0;
            hstyle_reg <= scc_pkg::ST_PLAIN;
            hvalid_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            prev_reg   <= prev_next;
            esc_reg    <= esc_next;
            clean_reg  <= clean_next;
            wlen_reg   <= wlen_next;
            long_reg   <= long_next;
            hstyle_reg <= hstyle_next;
            hvalid_reg <= hvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mask_reg <= mask_next;
        end
    end

endmodule

FILE: sv/scc_queue.sv
`timescale 1ns / 1ps
// scc_queue: short command queue between the front and back parts.
// Depends on scc_pkg.
module scc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output scc_pkg::cmd_t head_cmd
);

    scc_pkg::cmd_t               mem_reg [scc_pkg::QUEUE_DEPTH];
    logic [scc_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [scc_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [scc_pkg::QCNT_W-1:0]  count_reg, count_next;

    localparam logic [scc_pkg::QCNT_W-1:0] DEPTH_CNT = scc_pkg::QCNT_W'(scc_pkg::QUEUE_DEPTH);

    assign full       = count_reg == DEPTH_CNT;
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + scc_pkg::QCNT_W'(push) - scc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/scc_back.sv
`timescale 1ns / 1ps
// scc_back: expands one queued command into its run of style results, one per cycle while
// out_stall is low, into a registered output stage. Depends on scc_pkg.
module scc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  scc_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output scc_pkg::out_item_t out_data
);

    logic [scc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    scc_pkg::out_item_t        data_reg, data_next;

    logic [scc_pkg::CNT_W-1:0] b1, b2, b3;
    logic [2:0]                style;
    logic                      last;
    logic                      adv;

    always_comb
    begin
        b1 = scc_pkg::CNT_W'(head_cmd.h1_valid);
        b2 = b1 + scc_pkg::CNT_W'(head_cmd.w1_count);
        b3 = b2 + scc_pkg::CNT_W'(head_cmd.h2_valid);
        priority if (idx_reg < b1)
        begin
            style = head_cmd.h1_style;
        end
        else if (idx_reg < b2)
        begin
            style = head_cmd.w1_style;
        end
        else if (idx_reg < b3)
        begin
            style = head_cmd.h2_style;
        end
        else
        begin
            style = scc_pkg::ST_PLAIN;
        end
        last = idx_reg == head_cmd.total - 1'b1;
        adv  = head_valid && (!valid_reg || !out_stall);
        pop  = adv && last;

        idx_next   = idx_reg;
        valid_next = valid_reg && out_stall;
        data_next  = data_reg;
        if (adv)
        begin
            idx_next              = last ? '0 : idx_reg + 1'b1;
            valid_next            = 1'b1;
            data_next.style_code  = style;
            data_next.last_of_run = last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
